### hdl/degenerate_kmer_table_fill_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the degenerate k-mer table fill core
// Short forms of the concurrent checks used at the end of the core RTL module.
// ---------------------------------------------------------------------------
`ifndef DEGENERATE_KMER_TABLE_FILL_CORE_ASSERT_SVH
`define DEGENERATE_KMER_TABLE_FILL_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DKF_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DKF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dkf_pkg.sv
// ---------------------------------------------------------------------------
// dkf_pkg
// Request codes, IUPAC character codes and the base-set decoder.
// ---------------------------------------------------------------------------
package dkf_pkg;

    // Request types
    localparam logic REQ_SYMBOL = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Reset value of the scan width register
    localparam logic [2:0] SCAN_WIDTH_RESET = 3'd6;

    // ASCII codes of the recognized nucleotide letters
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_U = 8'h55;
    localparam logic [7:0] CH_V = 8'h56;
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_Y = 8'h59;

    // Base set: bit 0 A, bit 1 C, bit 2 G, bit 3 T
    typedef logic [3:0] t_base_set;

    function automatic t_base_set code_to_set(input logic [7:0] ch);
        t_base_set s;
        case (ch)
            CH_C:       s = 4'h2;
            CH_G:       s = 4'h4;
            CH_T, CH_U: s = 4'h8;
            CH_B:       s = 4'hE;
            CH_D:       s = 4'hD;
            CH_H:       s = 4'hB;
            CH_K:       s = 4'hC;
            CH_M:       s = 4'h3;
            CH_N:       s = 4'hF;
            CH_R:       s = 4'h5;
            CH_S:       s = 4'h6;
            CH_V:       s = 4'h7;
            CH_W:       s = 4'h9;
            CH_Y:       s = 4'hA;
            default:    s = 4'h1;
        endcase
        return s;
    endfunction

endpackage

### hdl/dkf_table_ram.sv
// ---------------------------------------------------------------------------
// dkf_table_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module dkf_table_ram #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/degenerate_kmer_table_fill_core.sv
// ---------------------------------------------------------------------------
// degenerate_kmer_table_fill_core
// Expands IUPAC DNA patterns into match-table entries and serves table reads.
// ---------------------------------------------------------------------------
// Usage: after reset the core sweeps every table word to zero, one word per
// cycle, NUM_TABLES * 4^MAX_WIDTH words (16384 with the defaults); busy
// stays high for the whole sweep while scan-width writes are still taken.
// A transfer happens when start is high and busy is low. A pattern character
// that does not end the pattern gives no result. The result of a read
// appears in the next cycle. A pattern end that is too long gives its result
// in the next cycle; otherwise the core walks all 4^n candidate indexes of
// the expansion through the table RAM, one index per cycle (read, OR the
// mask, write back in the cycle after the read), and the result strobe
// follows the walk. The table RAM's single read port sets that walk rate.
// Results are shown on the result ports for exactly one cycle, flagged by
// o_result_valid; the receiver cannot hold them off, so take them when the
// strobe is high.
// ---------------------------------------------------------------------------
module degenerate_kmer_table_fill_core #(
    parameter int MAX_WIDTH  = 6,
    parameter int NUM_TABLES = 4,
    parameter int WORD_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    // command
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_symbol,
    input  logic        i_last_symbol,
    input  logic        i_has_symbol,
    input  logic [1:0]  i_table_number,
    input  logic [31:0] i_mask,
    input  logic [11:0] i_read_index,
    // result
    output logic        o_result_valid,
    output logic        o_done_res,
    output logic [12:0] o_entries_updated,
    output logic        o_too_long,
    output logic [31:0] o_read_data
);

    import dkf_pkg::*;

    localparam int IDX_W      = 2 * MAX_WIDTH;
    localparam int TABLE_SIZE = 1 << IDX_W;
    localparam int DEPTH      = NUM_TABLES * TABLE_SIZE;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int LEN_W      = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W      = IDX_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DRAIN
    } t_state;

    // ---- registers ---------------------------------------------------------
    t_state               r_state,  n_state;
    logic [2:0]           r_scan_width;
    logic [LEN_W-1:0]     r_len,    n_len;
    logic                 r_ovf,    n_ovf;
    logic                 r_all_any, n_all_any;
    t_base_set            r_base_sets [MAX_WIDTH];
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    // walk control
    logic [IDX_W-1:0]     r_walk,   n_walk;
    logic [IDX_W-1:0]     r_last_idx, n_last_idx;
    logic [LEN_W-1:0]     r_n,      n_n;
    logic                 r_walk_all, n_walk_all;
    logic [1:0]           r_tbl;
    logic                 r_tbl_ok;
    logic [WORD_BITS-1:0] r_mask;
    logic [CNT_W-1:0]     r_count,  n_count;
    // write-back stage
    logic                 r_wb_valid, n_wb_valid;
    logic [ADDR_W-1:0]    r_wb_addr;
    // result
    logic                 r_res_valid, n_res_valid;
    logic                 r_res_done,  n_res_done;
    logic [12:0]          r_res_count, n_res_count;
    logic                 r_res_too_long, n_res_too_long;
    logic                 r_res_read_ok,  n_res_read_ok;

    // ---- combinational -----------------------------------------------------
    logic                 accept;
    logic                 acc_sym;
    logic                 acc_read;
    logic                 sym_we;
    t_base_set            sym_set;
    logic [3:0]           eff_w;
    logic                 too_long;
    logic                 hit;
    logic [ADDR_W-1:0]    walk_addr;
    logic [ADDR_W-1:0]    req_addr;
    logic                 req_ok;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    assign o_busy   = (r_state != S_IDLE);
    assign accept   = i_start && !o_busy;
    assign acc_sym  = accept && (i_req_type == REQ_SYMBOL);
    assign acc_read = accept && (i_req_type == REQ_READ);
    assign sym_set  = code_to_set(i_symbol);
    assign sym_we   = acc_sym && i_has_symbol && (32'(r_len) < MAX_WIDTH);

    // Clamp the scan width into 1..MAX_WIDTH
    always_comb begin
        if (r_scan_width == 3'd0) begin
            eff_w = 4'd1;
        end else if (4'(r_scan_width) > 4'(MAX_WIDTH)) begin
            eff_w = 4'(MAX_WIDTH);
        end else begin
            eff_w = 4'(r_scan_width);
        end
    end

    // Test one candidate index against the stored base sets, first char MSB
    always_comb begin
        int pos;
        logic [1:0] digit;
        hit = 1'b1;
        for (int p = 0; p < MAX_WIDTH; p++) begin
            pos   = int'(r_n) - 1 - p;
            digit = 2'(r_walk >> (2 * (pos < 0 ? 0 : pos)));
            if (!r_walk_all && (p < int'(r_n)) && !r_base_sets[p][digit]) begin
                hit = 1'b0;
            end
        end
    end

    assign walk_addr = (ADDR_W'(r_tbl) << IDX_W) | ADDR_W'(r_walk);
    assign req_addr  = (ADDR_W'(i_table_number) << IDX_W)
                     | ADDR_W'(IDX_W'(i_read_index));
    assign req_ok    = (32'(i_table_number) < NUM_TABLES)
                     && (32'(i_read_index) < TABLE_SIZE);

    // RAM port muxing: the clearing sweep owns the write port after reset
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = r_wb_valid;
            ram_waddr = r_wb_addr;
            ram_wdata = ram_rdata | r_mask;
        end
        ram_raddr = (r_state == S_IDLE) ? req_addr : walk_addr;
    end

    // Next-state logic
    always_comb begin
        n_state        = r_state;
        n_len          = r_len;
        n_ovf          = r_ovf;
        n_all_any      = r_all_any;
        n_clr_addr     = r_clr_addr;
        n_walk         = r_walk;
        n_last_idx     = r_last_idx;
        n_n            = r_n;
        n_walk_all     = r_walk_all;
        n_count        = r_count;
        n_wb_valid     = 1'b0;
        n_res_valid    = 1'b0;
        n_res_done     = r_res_done;
        n_res_count    = r_res_count;
        n_res_too_long = r_res_too_long;
        n_res_read_ok  = r_res_read_ok;
        too_long       = 1'b0;

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc_read) begin
                    // table word comes back from the RAM next cycle
                    n_res_valid    = 1'b1;
                    n_res_done     = 1'b0;
                    n_res_count    = '0;
                    n_res_too_long = 1'b0;
                    n_res_read_ok  = req_ok;
                end else if (acc_sym) begin
                    if (i_has_symbol) begin
                        if (i_symbol != CH_N) begin
                            n_all_any = 1'b0;
                        end
                        if (32'(r_len) < MAX_WIDTH) begin
                            n_len = r_len + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_last_symbol) begin
                        too_long = n_ovf || (4'(n_len) > eff_w);
                        if (too_long) begin
                            n_res_valid    = 1'b1;
                            n_res_done     = 1'b1;
                            n_res_count    = '0;
                            n_res_too_long = 1'b1;
                            n_res_read_ok  = 1'b0;
                        end else begin
                            // span is 4^n; all-N or empty patterns cover the width
                            n_n        = n_all_any ? LEN_W'(eff_w) : n_len;
                            n_walk_all = n_all_any;
                            n_walk     = '0;
                            n_count    = '0;
                            for (int k = 0; k < IDX_W; k++) begin
                                n_last_idx[k] = (k < 2 * int'(n_n));
                            end
                            n_state = S_WALK;
                        end
                        // drop the pattern state for the next pattern
                        n_len     = '0;
                        n_ovf     = 1'b0;
                        n_all_any = 1'b1;
                    end
                end
            end
            S_WALK: begin
                n_wb_valid = hit && r_tbl_ok;
                n_count    = r_count + CNT_W'(hit);
                n_walk     = r_walk + 1'b1;
                if (r_walk == r_last_idx) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last write-back lands at the end of this cycle
                n_res_valid    = 1'b1;
                n_res_done     = 1'b1;
                n_res_count    = 13'(r_count);
                n_res_too_long = 1'b0;
                n_res_read_ok  = 1'b0;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_scan_width   <= SCAN_WIDTH_RESET;
            r_len          <= '0;
            r_ovf          <= 1'b0;
            r_all_any      <= 1'b1;
            r_clr_addr     <= '0;
            r_walk         <= '0;
            r_last_idx     <= '0;
            r_n            <= '0;
            r_walk_all     <= 1'b0;
            r_count        <= '0;
            r_wb_valid     <= 1'b0;
            r_res_valid    <= 1'b0;
            r_res_done     <= 1'b0;
            r_res_count    <= '0;
            r_res_too_long <= 1'b0;
            r_res_read_ok  <= 1'b0;
        end else begin
            r_state        <= n_state;
            if (i_cfg_we) begin
                r_scan_width <= i_cfg_wdata;
            end
            r_len          <= n_len;
            r_ovf          <= n_ovf;
            r_all_any      <= n_all_any;
            r_clr_addr     <= n_clr_addr;
            r_walk         <= n_walk;
            r_last_idx     <= n_last_idx;
            r_n            <= n_n;
            r_walk_all     <= n_walk_all;
            r_count        <= n_count;
            r_wb_valid     <= n_wb_valid;
            r_res_valid    <= n_res_valid;
            r_res_done     <= n_res_done;
            r_res_count    <= n_res_count;
            r_res_too_long <= n_res_too_long;
            r_res_read_ok  <= n_res_read_ok;
        end
    end

    // Payload: base sets, walk target and write-back address
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < MAX_WIDTH; p++) begin
            if (sym_we && (32'(r_len) == p)) begin
                r_base_sets[p] <= sym_set;
            end
        end
        if (acc_sym && i_last_symbol) begin
            r_tbl    <= i_table_number;
            r_tbl_ok <= (32'(i_table_number) < NUM_TABLES);
            r_mask   <= WORD_BITS'(i_mask);
        end
        r_wb_addr <= walk_addr;
    end

    dkf_table_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_BITS)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result ports
    assign o_result_valid    = r_res_valid;
    assign o_done_res        = r_res_done;
    assign o_entries_updated = r_res_count;
    assign o_too_long        = r_res_too_long;
    assign o_read_data       = r_res_read_ok ? 32'(ram_rdata) : 32'd0;

    // ---- assertions --------------------------------------------------------
`include "degenerate_kmer_table_fill_core_assert.svh"

    `DKF_ASSERT_IMPL(a_len_bound, i_clk, i_rst_n, 1'b1, 32'(r_len) <= MAX_WIDTH, "pattern length overran base-set storage")
    `DKF_ASSERT_IMPL(a_wb_in_walk, i_clk, i_rst_n, r_wb_valid, (r_state == S_WALK) || (r_state == S_DRAIN), "write-back outside a table walk")
    `DKF_ASSERT_NEXT(a_read_result, i_clk, i_rst_n, acc_read, o_result_valid && !o_done_res, "read transfer gave no read result")
    `DKF_ASSERT_NEXT(a_walk_result, i_clk, i_rst_n, r_state == S_DRAIN, o_result_valid && o_done_res && !o_too_long, "table walk ended without a done result")

endmodule
